/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* rtl/core/sm4_pkg.sv */
package sm4_pkg;

  localparam int ROUNDS = 32;
  localparam int RND_W  = $clog2(ROUNDS);
  localparam int CK_W   = 5;

  localparam int PADDR_W      = 4;
  localparam int ADDR_IDX_BIT = 3;
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef logic [3:0][31:0]        word4_t;
  typedef logic [ROUNDS-1:0][31:0] rk_set_t;

  typedef struct packed {
    logic busy;
    logic last;
  } ks_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  localparam logic [31:0] FK [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [31:0] CK [32] = '{
    32'h00070E15, 32'h1C232A31, 32'h383F464D, 32'h545B6269,
    32'h70777E85, 32'h8C939AA1, 32'hA8AFB6BD, 32'hC4CBD2D9,
    32'hE0E7EEF5, 32'hFC030A11, 32'h181F262D, 32'h343B4249,
    32'h50575E65, 32'h6C737A81, 32'h888F969D, 32'hA4ABB2B9,
    32'hC0C7CED5, 32'hDCE3EAF1, 32'hF8FF060D, 32'h141B2229,
    32'h30373E45, 32'h4C535A61, 32'h686F767D, 32'h848B9299,
    32'hA0A7AEB5, 32'hBCC3CAD1, 32'hD8DFE6ED, 32'hF4FB0209,
    32'h10171E25, 32'h2C333A41, 32'h484F565D, 32'h646B7279
  };

  function automatic logic [31:0] sub_word(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Nonlinear step plus the diffusion used by the data rounds.
  function automatic logic [31:0] data_mix(input logic [31:0] v);
    logic [31:0] s;
    s = sub_word(v);
    return s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
             ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
  endfunction

  // Nonlinear step plus the lighter diffusion used by the key schedule.
  function automatic logic [31:0] key_mix(input logic [31:0] v);
    logic [31:0] s;
    s = sub_word(v);
    return s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
  endfunction

  // One cipher round: drop X0, shift the rest down, append the new word.
  function automatic word4_t round_step(input word4_t w, input logic [31:0] rk);
    logic [31:0] nw;
    nw = w[0] ^ data_mix(w[1] ^ w[2] ^ w[3] ^ rk);
    return {nw, w[3], w[2], w[1]};
  endfunction

endpackage

/* rtl/core/sm4_key_sched.sv */
module sm4_key_sched (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      key_high,
  input  logic [63:0]      key_low,
  output sm4_pkg::rk_set_t rk,
  output sm4_pkg::ks_stat_t stat
);

  localparam logic [sm4_pkg::RND_W-1:0] LAST = sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1);

  sm4_pkg::word4_t            kw;
  logic [sm4_pkg::RND_W-1:0]  cnt;
  logic                       busy;
  logic [31:0]                rk_new;

  assign rk_new = kw[0] ^ sm4_pkg::key_mix(kw[1] ^ kw[2] ^ kw[3]
                                           ^ sm4_pkg::CK[sm4_pkg::CK_W'(cnt)]);

  assign stat.busy = busy;
  assign stat.last = (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + sm4_pkg::RND_W'(1);
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Whiten the key with FK on start, then one round key per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      kw[0] <= key_high[63:32] ^ sm4_pkg::FK[0];
      kw[1] <= key_high[31:0]  ^ sm4_pkg::FK[1];
      kw[2] <= key_low[63:32]  ^ sm4_pkg::FK[2];
      kw[3] <= key_low[31:0]   ^ sm4_pkg::FK[3];
    end else if (busy) begin
      kw      <= {rk_new, kw[3], kw[2], kw[1]};
      rk[cnt] <= rk_new;
    end
  end

endmodule

/* rtl/core/sm4_block_encrypt_unit.sv */
// SM4 block encryption (ECB), one 128-bit block per request. The key is written
// through the APB-style port as two 64-bit registers (key_high at byte address 0,
// key_low at 8); after reset and after every key write, an iterative key
// expander derives the round keys one per cycle, and in_stall stays high until
// it finishes. After that the unrolled datapath takes a new request every cycle
// while the skid entry is empty: each of the ROUNDS pipeline stages holds one
// round, and an accepted block passes one round per stage and then the output
// register on its way out. A two-entry output buffer (output register plus skid
// entry) lets the pipeline keep taking requests while a finished result waits;
// apart from key expansion, in_stall rises only when the skid entry is occupied.
// Key writes are expected only while no request is in flight.
`include "assert_macros.svh"

module sm4_block_encrypt_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sm4_pkg::PADDR_W-1:0]  paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [63:0]                  block_high,
  input  logic [63:0]                  block_low,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [63:0]                  cipher_high,
  output logic [63:0]                  cipher_low
);

  localparam int LAST_STAGE = sm4_pkg::ROUNDS - 1;

  // Configuration registers.
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        reg_idx;
  logic        cfg_wr;
  logic        sched_start;

  // Key expander.
  sm4_pkg::rk_set_t  rk;
  sm4_pkg::ks_stat_t ks_stat;
  logic              sched_busy;

  // Round pipeline.
  sm4_pkg::word4_t             in_w;
  sm4_pkg::word4_t             st_w [sm4_pkg::ROUNDS];
  logic [sm4_pkg::ROUNDS-1:0]  st_v;
  logic                        accept;
  logic                        pipe_adv;
  logic                        pipe_out;

  // Output register and skid entry.
  sm4_pkg::word4_t out_w;
  sm4_pkg::word4_t sk_w;
  logic            sk_v;
  logic            out_free;

  // ---------------------------------------------------------------------------
  // Register port: decode on the 8-byte word index, full 64-bit data.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[sm4_pkg::ADDR_IDX_BIT];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      sm4_pkg::REG_KEY_HIGH: prdata = key_high;
      sm4_pkg::REG_KEY_LOW:  prdata = key_low;
      default:               prdata = key_high;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sm4_pkg::REG_KEY_HIGH: key_high <= pwdata;
        sm4_pkg::REG_KEY_LOW:  key_low  <= pwdata;
        default:               key_high <= pwdata;
      endcase
    end
  end

  // Kick the key expander in the cycle after a write so it sees the new key;
  // reset leaves a kick pending so the all-zero key gets expanded too.
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_start <= 1'b1;
    end else begin
      sched_start <= cfg_wr;
    end
  end

  sm4_key_sched u_key_sched (
    .clk      (clk),
    .rst      (rst),
    .start    (sched_start),
    .key_high (key_high),
    .key_low  (key_low),
    .rk       (rk),
    .stat     (ks_stat)
  );

  assign sched_busy = sched_start | ks_stat.busy;

  // ---------------------------------------------------------------------------
  // Input side: hold off requests while round keys are not ready or while the
  // skid entry is full (the whole pipeline freezes then).
  // ---------------------------------------------------------------------------
  assign pipe_adv = ~sk_v;
  assign in_stall = sched_busy | sk_v;
  assign accept   = in_valid & ~in_stall;

  // Big-endian word split: word 0 is the most significant of block_high.
  assign in_w = {block_low[31:0], block_low[63:32], block_high[31:0], block_high[63:32]};

  // ---------------------------------------------------------------------------
  // Round pipeline: stage i applies round i with round key i. Valid bits shift
  // alongside the data; bubbles simply flow through.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else if (pipe_adv) begin
      st_v[0] <= accept;
      for (int i = 1; i < sm4_pkg::ROUNDS; i++) begin
        st_v[i] <= st_v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      st_w[0] <= sm4_pkg::round_step(in_w, rk[0]);
      for (int i = 1; i < sm4_pkg::ROUNDS; i++) begin
        st_w[i] <= sm4_pkg::round_step(st_w[i-1], rk[i]);
      end
    end
  end

  // A finished block leaves the last stage this cycle.
  assign pipe_out = st_v[LAST_STAGE] & pipe_adv;

  // ---------------------------------------------------------------------------
  // Output register with skid entry. The output register refills from the skid
  // entry first, then straight from the pipeline; a block leaving the pipeline
  // while the output is stalled parks in the skid entry.
  // ---------------------------------------------------------------------------
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (out_free) begin
      out_valid <= sk_v | pipe_out;
      sk_v      <= 1'b0;
    end else if (pipe_out) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_w <= sk_v ? sk_w : st_w[LAST_STAGE];
    end else if (pipe_out) begin
      sk_w <= st_w[LAST_STAGE];
    end
  end

  // Final words come out reversed: B3 B2 in the high half, B1 B0 in the low.
  assign cipher_high = {out_w[3], out_w[2]};
  assign cipher_low  = {out_w[1], out_w[0]};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // The skid entry is only ever filled behind a waiting output.
  `ASSERT_IMPL(a_skid_behind_out, clk, rst, sk_v, out_valid)
  // A block leaving the pipeline into a stalled output must park in the skid.
  `ASSERT_NEXT(a_park_in_skid, clk, rst, out_valid && out_stall && pipe_out, sk_v)
  // The key expander stops after its last round key unless restarted.
  `ASSERT_NEXT(a_sched_ends, clk, rst, ks_stat.busy && ks_stat.last && !sched_start,
               !ks_stat.busy)

endmodule

/* tb/sm4_block_encrypt_unit_tb.sv */
`timescale 1ns / 1ps

module sm4_block_encrypt_unit_tb;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int HOLD_CYCLES    = 300;   // long output hold, enough to back up the pipeline
  localparam int SETTLE_CYCLES  = 40;    // time for the pipeline to drain, plus margin
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request or result moving
  localparam int RANDOM_PHASES  = 6;
  localparam int RANDOM_PER_KEY = 255;

  // Register map: 64-bit registers at 8-byte spacing.
  localparam logic [sm4_pkg::PADDR_W-1:0] ADDR_KEY_HIGH = 'h0;
  localparam logic [sm4_pkg::PADDR_W-1:0] ADDR_KEY_LOW  = 'h8;

  localparam logic [31:0] SYS_PARAM [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [7:0] SM4_SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block128_t;

  typedef enum logic [0:0] {SEND_STREAM, SEND_BURSTS} send_mode_e;
  typedef enum logic [1:0] {RECV_OPEN, RECV_RANDOM, RECV_PATTERN, RECV_BURSTY} recv_mode_e;

  // Clock, reset and every block input start at a known value.
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [sm4_pkg::PADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata     = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [63:0] block_high = '0;
  logic [63:0] block_low  = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;

  // Key as the block should hold it.
  logic [63:0] key_high_now = '0;
  logic [63:0] key_low_now  = '0;

  block128_t   plain_q[$];    // plaintext blocks waiting for the driver
  block128_t   cipher_q[$];   // ciphertext owed for accepted requests
  block128_t   next_block;

  int          sent_count  = 0;
  int          in_count    = 0;
  int          out_count   = 0;
  int          err_count   = 0;
  int          key_count   = 0;
  int          idle_cycles = 0;

  logic        in_took    = 1'b0;
  send_mode_e  send_mode  = SEND_STREAM;
  recv_mode_e  recv_mode  = RECV_OPEN;
  int          burst_left = 1;
  int          gap_left   = 0;
  int          recv_tick  = 0;
  int          recv_left  = 0;
  logic        recv_level = 1'b0;
  int          hold_left  = 0;
  bit          hold_go    = 1'b0;
  bit          hold_done  = 1'b0;

  sm4_block_encrypt_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .block_high  (block_high),
    .block_low   (block_low),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cipher arithmetic
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] v);
    return {SM4_SBOX[v[31:24]], SM4_SBOX[v[23:16]], SM4_SBOX[v[15:8]], SM4_SBOX[v[7:0]]};
  endfunction

  // Round constant r: byte j is 7 * (4r + j) mod 256.
  function automatic logic [31:0] round_constant(input int r);
    logic [31:0] c;
    for (int j = 0; j < 4; j++) begin
      c[31 - 8*j -: 8] = 8'((4*r + j) * 7);
    end
    return c;
  endfunction

  // Expand the key on the fly and run the rounds; the words leave reversed.
  function automatic block128_t sm4_encrypt(input logic [63:0] kh, input logic [63:0] kl,
                                            input block128_t pt);
    logic [31:0] k [4];
    logic [31:0] x [4];
    logic [31:0] s;
    logic [31:0] rk;
    logic [31:0] nx;
    block128_t   ct;
    k[0] = kh[63:32] ^ SYS_PARAM[0];
    k[1] = kh[31:0]  ^ SYS_PARAM[1];
    k[2] = kl[63:32] ^ SYS_PARAM[2];
    k[3] = kl[31:0]  ^ SYS_PARAM[3];
    x[0] = pt.hi[63:32];
    x[1] = pt.hi[31:0];
    x[2] = pt.lo[63:32];
    x[3] = pt.lo[31:0];
    for (int r = 0; r < sm4_pkg::ROUNDS; r++) begin
      s  = sbox_word(k[1] ^ k[2] ^ k[3] ^ round_constant(r % 32));
      rk = k[0] ^ s ^ rotl32(s, 13) ^ rotl32(s, 23);
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rk;
      s  = sbox_word(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ s ^ rotl32(s, 2) ^ rotl32(s, 10) ^ rotl32(s, 18) ^ rotl32(s, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    ct.hi = {x[3], x[2]};
    ct.lo = {x[1], x[0]};
    return ct;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: pop plaintext blocks, hold each until taken, and idle in
  // random gaps between bursts when bursts are selected.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled request as it is
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (plain_q.size() > 0) begin
      next_block = plain_q.pop_front();
      in_valid   <= 1'b1;
      block_high <= next_block.hi;
      block_low  <= next_block.lo;
      if (send_mode == SEND_BURSTS) begin
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall on the selected pattern. A one-time long hold
  // overrides the pattern so the pipeline and skid buffer fill and in_stall
  // rises while the driver keeps offering requests.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    recv_tick <= recv_tick + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      case (recv_mode)
        RECV_OPEN:    out_stall <= 1'b0;
        RECV_RANDOM:  out_stall <= ($urandom_range(0, 3) == 0);
        RECV_PATTERN: out_stall <= ((recv_tick % 7) < 3);
        RECV_BURSTY: begin
          if (recv_left == 0) begin
            recv_level <= ~recv_level;
            recv_left  <= $urandom_range(1, 12);
            out_stall  <= ~recv_level;
          end else begin
            recv_left <= recv_left - 1;
            out_stall <= recv_level;
          end
        end
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    block128_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        cipher_q.push_back(sm4_encrypt(key_high_now, key_low_now, {block_high, block_low}));
        in_count++;
      end
      if (out_valid && !out_stall) begin
        out_count++;
        if (cipher_q.size() == 0) begin
          report_mismatch("result with no request outstanding", cipher_high, '0);
        end else begin
          want = cipher_q.pop_front();
          if (cipher_high !== want.hi) report_mismatch("cipher_high", cipher_high, want.hi);
          if (cipher_low !== want.lo) report_mismatch("cipher_low", cipher_low, want.lo);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d of %0d results seen",
               idle_cycles, out_count, sent_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // One APB write: setup cycle, then access until pready.
  task automatic apb_write(input logic [sm4_pkg::PADDR_W-1:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_key_high(input logic [63:0] v);
    apb_write(ADDR_KEY_HIGH, v);
    key_high_now = v;
    key_count++;
  endtask

  task automatic write_key_low(input logic [63:0] v);
    apb_write(ADDR_KEY_LOW, v);
    key_low_now = v;
    key_count++;
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
    plain_q.push_back({hi, lo});
    sent_count++;
  endtask

  // Wait until every request is in and every result out, then let the
  // pipeline go quiet before touching the key again.
  task automatic settle_pipeline();
    @(posedge clk);
    while (in_count != sent_count || out_count != in_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly full random halves, with some corner values mixed in.
  function automatic logic [63:0] random_half();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(0, 63);
      3:       return ~(64'h1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    block128_t kat;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Check the predictor itself on the published test vector.
    kat = sm4_encrypt(64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                      {64'h0123456789ABCDEF, 64'hFEDCBA9876543210});
    if (kat.hi !== 64'h681EDF34D206965E) report_mismatch("vector high", kat.hi,
                                                         64'h681EDF34D206965E);
    if (kat.lo !== 64'h86B3E94F536E4246) report_mismatch("vector low", kat.lo,
                                                         64'h86B3E94F536E4246);

    // Reset key (all zero), block extremes, back to back.
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block('1, '0);
    queue_block('0, '1);
    queue_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    queue_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    settle_pipeline();

    // Standard key and plaintext.
    write_key_high(64'h0123456789ABCDEF);
    write_key_low(64'hFEDCBA9876543210);
    queue_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    queue_block('0, '0);
    queue_block('1, '1);
    settle_pipeline();

    // All-ones key, light random stall on the output.
    recv_mode = RECV_RANDOM;
    write_key_high('1);
    write_key_low('1);
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block({$urandom, $urandom}, {$urandom, $urandom});
    queue_block({$urandom, $urandom}, {$urandom, $urandom});
    settle_pipeline();

    // Rewrite one half only; the other keeps its value.
    write_key_high('0);
    queue_block('0, '0);
    queue_block('1, '0);
    queue_block({$urandom, $urandom}, {$urandom, $urandom});
    settle_pipeline();

    write_key_low('0);
    queue_block('0, '1);
    queue_block('1, '1);
    queue_block({$urandom, $urandom}, {$urandom, $urandom});
    settle_pipeline();

    // Random keys and blocks, each phase with its own traffic shape.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 6)
        0: begin send_mode = SEND_BURSTS; recv_mode = RECV_RANDOM;  end
        1: begin send_mode = SEND_STREAM; recv_mode = RECV_PATTERN; end
        2: begin send_mode = SEND_BURSTS; recv_mode = RECV_BURSTY;  end
        3: begin send_mode = SEND_STREAM; recv_mode = RECV_OPEN; hold_go = 1'b1; end
        4: begin send_mode = SEND_BURSTS; recv_mode = RECV_OPEN;    end
        default: begin send_mode = SEND_STREAM; recv_mode = RECV_BURSTY; end
      endcase
      write_key_high({$urandom, $urandom});
      write_key_low({$urandom, $urandom});
      for (int i = 0; i < RANDOM_PER_KEY; i++) begin
        queue_block(random_half(), random_half());
      end
      settle_pipeline();
    end

    while (cipher_q.size() > 0) begin
      kat = cipher_q.pop_front();
      report_mismatch("result never arrived, cipher_high", 'x, kat.hi);
    end

    $display("Encrypted %0d blocks under %0d key register writes, %0d results checked",
             sent_count, key_count, out_count);
    $display("Traffic: bursts and gaps on requests, random/periodic/bursty output stalls, "
             , "one %0d-cycle output hold", HOLD_CYCLES);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/sm4_pkg.sv
rtl/core/sm4_key_sched.sv
rtl/core/sm4_block_encrypt_unit.sv
tb/sm4_block_encrypt_unit_tb.sv
